/* rtl/b64enc_pkg.sv */
package b64enc_pkg;

	localparam int unsigned CharWidth  = 8;
	localparam int unsigned RunLength  = 4;
	localparam int unsigned RunCntBits = 3;

	localparam logic [CharWidth-1:0] PadChar = 8'h3d;	// '='
	// Digit value that NUL takes under the wrapping rule; used for an odd final digit.
	localparam logic [CharWidth-1:0] NulDigit = 8'ha9;

	typedef logic [CharWidth-1:0] char_t;
	typedef logic [5:0] sextet_t;

	// Digit value of one character, taken modulo 256 for anything outside the digit ranges.
	function automatic char_t digit_value(input char_t c);
		char_t v;
		priority if (c >= 8'h30 && c <= 8'h39) begin
			v = c - 8'h30;
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			v = c - 8'd55;
		end else begin
			v = c - 8'd87;
		end
		return v;
	endfunction

	// Standard base64 alphabet.
	function automatic char_t b64_symbol(input sextet_t idx);
		char_t s;
		priority if (idx < 6'd26) begin
			s = {2'b00, idx} + 8'h41;
		end else if (idx < 6'd52) begin
			s = {2'b00, idx} + 8'd71;
		end else if (idx < 6'd62) begin
			s = {2'b00, idx} - 8'd4;
		end else if (idx == 6'd62) begin
			s = 8'h2b;
		end else begin
			s = 8'h2f;
		end
		return s;
	endfunction

endpackage

/* rtl/hex_text_to_base64_encoder.sv */
// Channel  | Direction | Payload
// s_axis   | in        | tdata[7:0] = hex_char, tlast = text_end
// m_axis   | out       | tdata[7:0] = b64_char, tlast = run_last, tuser[0] = text_done
//
// Each character word is taken into an input register and handled from there; a new word
// can be taken in every cycle while no word waits there. A word that completes a group of
// three bytes, or ends the text, loads four characters into an output shift register, which
// sends one per cycle while m_axis is ready. Such a word waits in the input register until
// the shift register is empty; all other words are taken without waiting. Reset is
// asynchronous and clears all control state. Back-pressure on m_axis only holds the shift
// register and never reaches s_axis tready in the same cycle.
module hex_text_to_base64_encoder
	import b64enc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,	// [7:0] hex_char
	input  logic       s_axis_tlast,	// text_end
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,	// [7:0] b64_char
	output logic       m_axis_tlast,	// run_last
	output logic [0:0] m_axis_tuser	// [0] text_done
);

	// Input register.
	logic  valid_s1;
	char_t hex_char_s1;
	logic  text_end_s1;

	// Text state: held first digit and the bytes of the current group.
	char_t      high_val_q;
	logic       high_held_q;
	char_t      grp_q [2];
	logic [1:0] grp_cnt_q;

	// Output run.
	char_t                 run_q [RunLength];
	logic [RunCntBits-1:0] out_cnt_q;
	logic                  done_q;

	logic  needs_out;
	logic  consume;
	logic  load_run;
	char_t dv;
	char_t new_byte;
	char_t b0;
	char_t b1;
	char_t run_d [RunLength];

	// A word yields characters when it completes a byte that fills a group, or ends the text.
	assign needs_out = text_end_s1 || (high_held_q && grp_cnt_q == 2'd2);
	assign consume   = valid_s1 && (!needs_out || out_cnt_q == '0);
	assign load_run  = consume && needs_out;
	assign s_axis_tready = !valid_s1 || consume;

	always_comb begin
		dv = digit_value(hex_char_s1);
		// An odd final digit becomes the high nibble, with NUL standing in as the low digit.
		if (high_held_q) begin
			new_byte = {high_val_q[3:0], 4'b0000} + dv;
		end else begin
			new_byte = {dv[3:0], 4'b0000} + NulDigit;
		end

		b0 = (grp_cnt_q == 2'd0) ? new_byte : grp_q[0];
		unique case (grp_cnt_q)
			2'd0:    b1 = '0;
			2'd1:    b1 = new_byte;
			default: b1 = grp_q[1];
		endcase

		run_d[0] = b64_symbol(b0[7:2]);
		run_d[1] = b64_symbol({b0[1:0], b1[7:4]});
		if (grp_cnt_q == 2'd2) begin
			// Full group of three bytes.
			run_d[2] = b64_symbol({b1[3:0], new_byte[7:6]});
			run_d[3] = b64_symbol(new_byte[5:0]);
		end else begin
			// End of text with one or two bytes left: padded.
			run_d[2] = (grp_cnt_q == 2'd1) ? b64_symbol({b1[3:0], 2'b00}) : PadChar;
			run_d[3] = PadChar;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			hex_char_s1 <= s_axis_tdata;
			text_end_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_val_q  <= '0;
			high_held_q <= 1'b0;
			grp_cnt_q   <= 2'd0;
		end else if (consume) begin
			if (!high_held_q && !text_end_s1) begin
				high_val_q  <= dv;
				high_held_q <= 1'b1;
			end else begin
				high_val_q  <= '0;
				high_held_q <= 1'b0;
				if (text_end_s1 || grp_cnt_q == 2'd2) begin
					grp_cnt_q <= 2'd0;
				end else begin
					grp_cnt_q <= grp_cnt_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (consume && (high_held_q || text_end_s1) && grp_cnt_q != 2'd2) begin
			grp_q[grp_cnt_q[0]] <= new_byte;
		end
	end

	// Output shift register: the head is always on the port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			done_q    <= 1'b0;
		end else if (load_run) begin
			out_cnt_q <= RunCntBits'(RunLength);
			done_q    <= text_end_s1;
		end else if (m_axis_tvalid && m_axis_tready) begin
			out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_run) begin
			run_q <= run_d;
		end else if (m_axis_tvalid && m_axis_tready) begin
			for (int i = 0; i < RunLength - 1; i++) begin
				run_q[i] <= run_q[i+1];
			end
		end
	end

	assign m_axis_tvalid   = (out_cnt_q != '0);
	assign m_axis_tdata    = run_q[0];
	assign m_axis_tlast    = (out_cnt_q == RunCntBits'(1));
	assign m_axis_tuser[0] = done_q && (out_cnt_q == RunCntBits'(1));

	a_done_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tlast)
		else $error("text_done without run_last");

	a_load_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		load_run |-> !m_axis_tvalid)
		else $error("run loaded over unsent characters");

	a_group_count: assert property (@(posedge clk) disable iff (!arst_n)
		grp_cnt_q != 2'd3)
		else $error("byte group overflow");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		consume && text_end_s1 |=> grp_cnt_q == 2'd0 && !high_held_q && out_cnt_q == 3'd4)
		else $error("state not cleared at end of text");

endmodule
